// ===== rtl/icaf_pkg.sv =====
// shared types, constants and functions of the imu attitude filter
package icaf_pkg;

    localparam int CordicSteps = 16;
    localparam int StepW = 5;

    localparam logic [1:0] REG_BLEND = 2'd0;
    localparam logic [1:0] REG_DT    = 2'd1;
    localparam logic [1:0] REG_GYRO  = 2'd2;

    localparam logic [15:0] BLEND_RESET = 16'd64225;
    localparam logic [15:0] DT_RESET    = 16'd655;
    localparam logic [15:0] GYRO_RESET  = 16'd500;

    localparam logic signed [23:0] ANG_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] ANG_MIN = -24'sh800000;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } imu_in_t;

    typedef struct packed {
        logic signed [23:0] pitch_out;
        logic signed [23:0] roll_out;
        logic signed [23:0] yaw_out;
    } imu_out_t;

    // arctangent of 2^-i in 1/65536 degree
    function automatic logic [21:0] atan_lut(input logic [StepW-1:0] i);
        logic [21:0] r;
        begin
            case (i)
                5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967;
                5'd2: r = 22'd919879;   5'd3: r = 22'd466945;
                5'd4: r = 22'd234379;   5'd5: r = 22'd117304;
                5'd6: r = 22'd58666;    5'd7: r = 22'd29335;
                5'd8: r = 22'd14668;    5'd9: r = 22'd7334;
                5'd10: r = 22'd3667;    5'd11: r = 22'd1833;
                5'd12: r = 22'd917;     5'd13: r = 22'd458;
                5'd14: r = 22'd229;     5'd15: r = 22'd115;
                5'd16: r = 22'd57;      5'd17: r = 22'd29;
                5'd18: r = 22'd14;      5'd19: r = 22'd7;
                5'd20: r = 22'd4;       5'd21: r = 22'd2;
                5'd22: r = 22'd1;       default: r = 22'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/icaf_front.sv =====
// input stage: takes a sample beat and precomputes the squared magnitude of accel y and z
module icaf_front
    import icaf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  imu_in_t        in_data,
    output logic           q_valid,
    input  logic           q_ready,
    output imu_in_t        q_data,
    output logic [31:0]    q_sumsq
);
    logic    full_reg;
    imu_in_t data_reg;
    logic [31:0] sumsq_reg;
    logic signed [31:0] ysq, zsq;

    assign ysq = 32'(in_data.accel_y * in_data.accel_y);
    assign zsq = 32'(in_data.accel_z * in_data.accel_z);
    assign in_ready = !full_reg || q_ready;
    assign q_valid = full_reg;
    assign q_data = data_reg;
    assign q_sumsq = sumsq_reg;

    // one-entry queue toward the back end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
            sumsq_reg <= ysq + zsq;
        end
    end

endmodule

// ===== rtl/icaf_back.sv =====
// sequencer: square root, two cordic passes, rate scaling, bias updates, prediction, blend and yaw
module icaf_back
    import icaf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  imu_in_t        q_data,
    input  logic [31:0]    q_sumsq,
    input  logic [15:0]    blend_weight,
    input  logic [15:0]    time_step,
    input  logic [15:0]    gyro_dps_per_count,
    output logic           out_valid,
    input  logic           out_ready,
    output imu_out_t       out_data
);
    localparam logic [3:0] S_IDLE = 4'd0, S_SQRT = 4'd1, S_CPRE = 4'd2, S_CITER = 4'd3,
        S_RATE = 4'd4, S_BIAS1 = 4'd5, S_BIAS2 = 4'd6, S_PRED1 = 4'd7, S_PRED2 = 4'd8,
        S_BL1 = 4'd9, S_BL2 = 4'd10, S_BL3 = 4'd11, S_OUT = 4'd12;

    logic [3:0] state_reg;
    logic [4:0] cnt_reg;
    logic       pass_reg;
    imu_in_t    s_reg;
    logic [47:0] rem_reg;
    logic [23:0] root_reg;
    logic signed [26:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic signed [23:0] apitch_reg, aroll_reg;
    logic signed [31:0] rx_reg, ry_reg, rz_reg;
    logic signed [31:0] pbias_reg, rbias_reg;
    logic signed [49:0] prod_reg;
    logic signed [25:0] ppred_reg, rpred_reg;
    logic signed [23:0] pitch_reg, roll_reg, yaw_reg;
    logic signed [47:0] acc_reg;
    logic       ovalid_reg;
    imu_out_t   odata_reg;

    // one sqrt step: takes two radicand bits and yields one result bit
    logic [49:0] trial;
    logic [47:0] radicand;
    logic [1:0]  pair;
    logic [47:0] part_hi_reg;
    assign radicand = {q_sumsq, 16'd0};
    assign pair = rem_reg[47:46];
    logic [49:0] part;
    assign part = {part_hi_reg, pair};
    assign trial = part - {24'd0, root_reg, 2'b01};

    // cordic step
    logic signed [26:0] dx, dy;
    logic signed [22:0] ang;
    assign dx = cy_reg >>> cnt_reg;
    assign dy = cx_reg >>> cnt_reg;
    assign ang = $signed({1'b0, atan_lut(cnt_reg)});

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        begin
            if (v > 48'sd8388607) return ANG_MAX;
            if (v < -48'sd8388608) return ANG_MIN;
            return v[23:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        begin
            if (v > 48'sh7FFFFFFF) return 32'sh7FFFFFFF;
            if (v < -48'sh80000000) return 32'sh80000000;
            return v[31:0];
        end
    endfunction

    logic signed [31:0] zr;
    logic signed [23:0] zround;
    assign zr = cz_reg + 32'sd128;
    assign zround = 24'(zr >>> 8);
    logic level;
    assign level = (apitch_reg > -24'sd256) && (apitch_reg < 24'sd256)
        && (aroll_reg > -24'sd256) && (aroll_reg < 24'sd256);

    logic signed [16:0] dts, alph;
    logic signed [17:0] ialph;
    assign dts = $signed({1'b0, time_step});
    assign alph = $signed({1'b0, blend_weight});
    assign ialph = 18'sd65536 - 18'(alph);

    assign q_ready = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data = odata_reg;

    logic signed [49:0] step24;
    assign step24 = (prod_reg + 50'sh800000) >>> 24;

    // result beat register, held until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            odata_reg <= '0;
        end
        else if (state_reg == S_OUT && (!ovalid_reg || out_ready))
        begin
            ovalid_reg <= 1'b1;
            odata_reg <= '{pitch_out: pitch_reg, roll_out: roll_reg, yaw_out: yaw_reg};
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pitch_reg <= '0; roll_reg <= '0; yaw_reg <= '0;
            pbias_reg <= '0; rbias_reg <= '0;
            cnt_reg <= '0; pass_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        s_reg <= q_data;
                        rem_reg <= radicand;
                        part_hi_reg <= '0;
                        root_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (!trial[49])
                    begin
                        part_hi_reg <= trial[47:0];
                        root_reg <= {root_reg[22:0], 1'b1};
                    end
                    else
                    begin
                        part_hi_reg <= part[47:0];
                        root_reg <= {root_reg[22:0], 1'b0};
                    end
                    rem_reg <= {rem_reg[45:0], 2'b00};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd23)
                    begin
                        pass_reg <= 1'b0;
                        state_reg <= S_CPRE;
                    end
                end
                S_CPRE:
                begin
                    logic signed [26:0] x0, y0;
                    x0 = pass_reg ? 27'(s_reg.accel_z * 256) : $signed({3'd0, root_reg});
                    y0 = pass_reg ? 27'(s_reg.accel_y * 256) : 27'(-(s_reg.accel_x * 256));
                    if (x0 < 0)
                    begin
                        cx_reg <= -x0; cy_reg <= -y0;
                        cz_reg <= (y0 >= 0) ? 32'sd11796480 : -32'sd11796480;
                    end
                    else
                    begin
                        cx_reg <= x0; cy_reg <= y0; cz_reg <= '0;
                    end
                    state_reg <= S_CITER;
                    // zero vector skips the rotations and gives zero
                    cnt_reg <= (x0 == 0 && y0 == 0) ? 5'(CordicSteps) : 5'd0;
                end
                S_CITER:
                begin
                    if (cnt_reg < 5'(CordicSteps))
                    begin
                        if (cy_reg >= 0)
                        begin
                            cx_reg <= cx_reg + dx; cy_reg <= cy_reg - dy;
                            cz_reg <= cz_reg + 32'(ang);
                        end
                        else
                        begin
                            cx_reg <= cx_reg - dx; cy_reg <= cy_reg + dy;
                            cz_reg <= cz_reg - 32'(ang);
                        end
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                    else
                    begin
                        if (!pass_reg)
                        begin
                            apitch_reg <= zround;
                            pass_reg <= 1'b1;
                            state_reg <= S_CPRE;
                        end
                        else
                        begin
                            aroll_reg <= zround;
                            state_reg <= S_RATE;
                        end
                    end
                end
                S_RATE:
                begin
                    rx_reg <= 32'(s_reg.rate_x * $signed({1'b0, gyro_dps_per_count}));
                    ry_reg <= 32'(s_reg.rate_y * $signed({1'b0, gyro_dps_per_count}));
                    rz_reg <= 32'(s_reg.rate_z * $signed({1'b0, gyro_dps_per_count}));
                    state_reg <= S_BIAS1;
                end
                S_BIAS1:
                begin
                    prod_reg <= 50'(ry_reg * dts);
                    state_reg <= S_BIAS2;
                end
                S_BIAS2:
                begin
                    if (level)
                    begin
                        if (pass_reg)
                        begin
                            pbias_reg <= sat32(48'(pbias_reg) + 48'(((
                                64'(prod_reg) * 64'sd655) + 64'sh80000000) >>> 32));
                            prod_reg <= 50'(rx_reg * dts);
                            pass_reg <= 1'b0;
                        end
                        else
                        begin
                            rbias_reg <= sat32(48'(rbias_reg) + 48'(((
                                64'(prod_reg) * 64'sd655) + 64'sh80000000) >>> 32));
                            state_reg <= S_PRED1;
                            pass_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_PRED1;
                        pass_reg <= 1'b1;
                    end
                end
                S_PRED1:
                begin
                    prod_reg <= 50'((pass_reg ? (ry_reg - pbias_reg)
                        : (rx_reg - rbias_reg)) * dts);
                    state_reg <= S_PRED2;
                end
                S_PRED2:
                begin
                    if (pass_reg)
                    begin
                        ppred_reg <= 26'(pitch_reg + step24);
                        pass_reg <= 1'b0;
                        state_reg <= S_PRED1;
                    end
                    else
                    begin
                        rpred_reg <= 26'(roll_reg + step24);
                        prod_reg <= 50'(rz_reg * dts);
                        pass_reg <= 1'b1;
                        state_reg <= S_BL1;
                    end
                end
                S_BL1:
                begin
                    yaw_reg <= sat24(48'(yaw_reg) + 48'(step24));
                    acc_reg <= 48'(ppred_reg * alph) + 48'(apitch_reg * ialph);
                    state_reg <= S_BL2;
                end
                S_BL2:
                begin
                    pitch_reg <= sat24((acc_reg + 48'sd32768) >>> 16);
                    acc_reg <= 48'(rpred_reg * alph) + 48'(aroll_reg * ialph);
                    state_reg <= S_BL3;
                end
                S_BL3:
                begin
                    roll_reg <= sat24((acc_reg + 48'sd32768) >>> 16);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ovalid_reg || out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // new item only taken while sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |=> state_reg == S_SQRT)
        else $error("sample not started");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!ovalid_reg || out_ready)) |=> out_valid)
        else $error("result not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CITER) |-> cnt_reg <= 5'(CordicSteps))
        else $error("cordic count overrun");

endmodule

// ===== rtl/imu_complementary_attitude_filter.sv =====
// top level of the complementary attitude filter
// a sample beat passes the front queue, then the sequencer; bias updates only when level
// (take, 24 sqrt steps, two cordic passes, rate, bias, prediction, blend, out)
// the sequencer takes no sample until the last is done; a stalled result beat holds it
// the front queue takes the next beat while the back end still works
// reset clears all estimates and biases and loads the default registers
module imu_complementary_attitude_filter
    import icaf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  imu_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output imu_out_t    out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic [15:0] blend_reg, dt_reg, gyro_reg;
    logic q_valid, q_ready;
    imu_in_t q_data;
    logic [31:0] q_sumsq;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg <= BLEND_RESET;
            dt_reg <= DT_RESET;
            gyro_reg <= GYRO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLEND: blend_reg <= cfg_data;
                REG_DT:    dt_reg <= cfg_data;
                REG_GYRO:  gyro_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    icaf_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .q_sumsq(q_sumsq)
    );

    icaf_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .q_sumsq(q_sumsq), .blend_weight(blend_reg),
        .time_step(dt_reg), .gyro_dps_per_count(gyro_reg),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule

// ===== tb/imu_complementary_attitude_filter_tb.sv =====
// testbench for the imu complementary attitude filter: directed and random samples against a local predictor
`timescale 1ns / 100ps

module imu_complementary_attitude_filter_tb;
    import icaf_pkg::*;

    localparam int NumRandom = 1700;
    localparam int WatchdogLimit = 20000;
    localparam int SettleCycles = 200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    imu_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    imu_out_t    out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_ready_seen;

    imu_complementary_attitude_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of registers and state
    longint alpha_q16;
    longint dt_q16;
    longint gyro_q16;
    longint pitch_angle;
    longint roll_angle;
    longint yaw_angle;
    longint pitch_bias;
    longint roll_bias;

    imu_in_t  sample_queue[$];
    imu_out_t attitude_queue[$];
    int       fail_count;
    int       idle_cycles;
    int       burst_left;
    int       gap_left;
    int       stall_phase;
    bit       hold_sender;

    const longint atan_deg_q16[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // arithmetic shift with add-half rounding
    function automatic longint rnd_shift(input longint x, input int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // atan2 by vectoring rotations, 1/256 degree
    function automatic longint vec_angle(input longint y, input longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CordicSteps && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += atan_deg_q16[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_deg_q16[i];
            end
        end
        return rnd_shift(z, 8);
    endfunction

    // advance the predicted attitude by one sample
    function automatic imu_out_t attitude_update(input imu_in_t s);
        longint ax;
        longint ay;
        longint az;
        longint rx;
        longint ry;
        longint rz;
        longint mag;
        longint acc_pitch;
        longint acc_roll;
        longint pred;
        imu_out_t r;
        ax = longint'(s.accel_x);
        ay = longint'(s.accel_y);
        az = longint'(s.accel_z);
        rx = longint'(s.rate_x) * gyro_q16;
        ry = longint'(s.rate_y) * gyro_q16;
        rz = longint'(s.rate_z) * gyro_q16;
        mag = int_sqrt(longint'(ay * ay + az * az) << 16);
        acc_pitch = vec_angle(-ax * 256, mag);
        acc_roll = vec_angle(ay * 256, az * 256);
        if (acc_pitch > -256 && acc_pitch < 256 && acc_roll > -256 && acc_roll < 256)
        begin
            pitch_bias = sat(pitch_bias + rnd_shift(ry * dt_q16 * 655, 32),
                             -64'sd2147483648, 64'sd2147483647);
            roll_bias = sat(roll_bias + rnd_shift(rx * dt_q16 * 655, 32),
                            -64'sd2147483648, 64'sd2147483647);
        end
        pred = pitch_angle + rnd_shift((ry - pitch_bias) * dt_q16, 24);
        pitch_angle = sat(rnd_shift(alpha_q16 * pred + (65536 - alpha_q16) * acc_pitch, 16),
                          -8388608, 8388607);
        pred = roll_angle + rnd_shift((rx - roll_bias) * dt_q16, 24);
        roll_angle = sat(rnd_shift(alpha_q16 * pred + (65536 - alpha_q16) * acc_roll, 16),
                         -8388608, 8388607);
        yaw_angle = sat(yaw_angle + rnd_shift(rz * dt_q16, 24), -8388608, 8388607);
        r.pitch_out = pitch_angle[23:0];
        r.roll_out = roll_angle[23:0];
        r.yaw_out = yaw_angle[23:0];
        return r;
    endfunction

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // driver: bursts and gaps, new beat on the falling edge
    always @(negedge clk)
    begin
        if (rst_n && !hold_sender && (!in_valid || in_ready_seen))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (sample_queue.size() > 0)
            begin
                in_data <= sample_queue.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 6);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 150);
                end
            end
            else
                in_valid <= 1'b0;
        end
        else if (in_valid && in_ready_seen)
            in_valid <= 1'b0;
    end

    // input acceptance as seen at the last rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ready_seen <= 1'b0;
        else
            in_ready_seen <= in_valid && in_ready;
    end

    // predict at accept time so configuration order is kept
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            attitude_queue.push_back(attitude_update(in_data));
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[9:8] == 2'd3)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        imu_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (attitude_queue.size() == 0)
            begin
                $display("%0t unexpected beat actual %h", $time, out_data);
                fail_count++;
            end
            else
            begin
                want = attitude_queue.pop_front();
                if (want.pitch_out !== out_data.pitch_out)
                begin
                    $display("%0t pitch expected %0d actual %0d", $time,
                             want.pitch_out, out_data.pitch_out);
                    fail_count++;
                end
                if (want.roll_out !== out_data.roll_out)
                begin
                    $display("%0t roll expected %0d actual %0d", $time,
                             want.roll_out, out_data.roll_out);
                    fail_count++;
                end
                if (want.yaw_out !== out_data.yaw_out)
                begin
                    $display("%0t yaw expected %0d actual %0d", $time,
                             want.yaw_out, out_data.yaw_out);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchdogLimit)
        begin
            $display("imu_complementary_attitude_filter: mismatch");
            $finish;
        end
    end

    function automatic imu_in_t random_sample();
        imu_in_t s;
        s = imu_in_t'({$urandom, $urandom, $urandom});
        case ($urandom_range(0, 3))
            0:
            begin
                // near level, feeds the bias creep
                s.accel_x = 16'($urandom_range(0, 60) - 30);
                s.accel_y = 16'($urandom_range(0, 60) - 30);
                s.accel_z = 16'($urandom_range(14000, 18000));
                s.rate_x = 16'($urandom_range(0, 2000) - 1000);
                s.rate_y = 16'($urandom_range(0, 2000) - 1000);
                s.rate_z = 16'($urandom_range(0, 2000) - 1000);
            end
            1:
            begin
                s.accel_x = 16'($urandom_range(0, 8000) - 4000);
                s.accel_y = 16'($urandom_range(0, 8000) - 4000);
                s.accel_z = 16'($urandom_range(0, 32000) - 16000);
            end
            default:
            begin
            end
        endcase
        return s;
    endfunction

    task automatic push_sample(input int ax, input int ay, input int az,
                               input int rx, input int ry, input int rz);
        imu_in_t s;
        s.accel_x = 16'(ax);
        s.accel_y = 16'(ay);
        s.accel_z = 16'(az);
        s.rate_x = 16'(rx);
        s.rate_y = 16'(ry);
        s.rate_z = 16'(rz);
        sample_queue.push_back(s);
    endtask

    // wait for all samples accepted and all results back, then let it settle
    task automatic drain();
        while (sample_queue.size() > 0 || in_valid || attitude_queue.size() > 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // register write, predictor updated at the same edge
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_BLEND: alpha_q16 = longint'(val);
            REG_DT:    dt_q16 = longint'(val);
            REG_GYRO:  gyro_q16 = longint'(val);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_BLEND;
        cfg_data = '0;
        fail_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        hold_sender = 1'b0;
        alpha_q16 = longint'(BLEND_RESET);
        dt_q16 = longint'(DT_RESET);
        gyro_q16 = longint'(GYRO_RESET);
        pitch_angle = 0;
        roll_angle = 0;
        yaw_angle = 0;
        pitch_bias = 0;
        roll_bias = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, zero vector, negative axis, level
        push_sample(0, 0, 0, 0, 0, 0);
        push_sample(32767, 32767, 32767, 32767, 32767, 32767);
        push_sample(-32768, -32768, -32768, -32768, -32768, -32768);
        push_sample(0, 0, -16384, 100, -100, 50);
        push_sample(0, 0, 16384, 1000, 1000, 1000);
        push_sample(10, -10, 16384, -32768, 32767, -32768);
        push_sample(-32768, 0, 0, 0, 0, 0);
        push_sample(32767, 0, 0, 0, 0, 0);
        push_sample(0, 32767, 0, 0, 0, 0);
        push_sample(0, -32768, -1, 0, 0, 0);
        drain();

        // zero dt and gyro scale, full blend extremes
        write_reg(REG_DT, 16'd0);
        write_reg(REG_GYRO, 16'd0);
        write_reg(REG_BLEND, 16'd0);
        push_sample(100, 200, 16000, 32767, 32767, 32767);
        push_sample(-5000, 3000, -9000, -32768, -32768, -32768);
        drain();
        write_reg(REG_BLEND, 16'hFFFF);
        write_reg(REG_DT, 16'hFFFF);
        write_reg(REG_GYRO, 16'hFFFF);
        for (int i = 0; i < 8; i++)
            push_sample(0, 0, 16384, 32767, 32767, 32767);
        for (int i = 0; i < 8; i++)
            push_sample(0, 0, 16384, -32768, -32768, -32768);
        drain();

        // random phases across several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_BLEND, BLEND_RESET);
                    write_reg(REG_DT, DT_RESET);
                    write_reg(REG_GYRO, GYRO_RESET);
                end
                1:
                begin
                    write_reg(REG_BLEND, 16'd1);
                    write_reg(REG_DT, 16'd1);
                    write_reg(REG_GYRO, 16'd1);
                end
                2:
                begin
                    write_reg(REG_BLEND, 16'hFFFF);
                    write_reg(REG_DT, 16'hFFFF);
                    write_reg(REG_GYRO, 16'hFFFF);
                end
                default:
                begin
                    write_reg(REG_BLEND, 16'($urandom));
                    write_reg(REG_DT, 16'($urandom));
                    write_reg(REG_GYRO, 16'($urandom));
                end
            endcase
            for (int i = 0; i < NumRandom / 6; i++)
                sample_queue.push_back(random_sample());
            // sender pauses once until every result is back
            if (ph == 3)
            begin
                while (sample_queue.size() > NumRandom / 12)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (in_valid || attitude_queue.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            drain();
        end

        if (fail_count == 0)
            $display("imu_complementary_attitude_filter: match");
        else
            $display("imu_complementary_attitude_filter: mismatch");
        $finish;
    end

endmodule
